// File: src/icdf_pkg.sv
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared constants and types of the inverse-CDF angle sampler: table geometry,
// field widths, energy band reciprocal, item kinds and layout, table write port.
// ----------------------------------------------------------------------------
`default_nettype none

package icdf_pkg;

  // table geometry
  localparam int ROWS          = 70;
  localparam int ENTRIES       = 181;
  localparam int FRACTION_BITS = 16;
  localparam int DEPTH         = ROWS * ENTRIES;

  localparam int ENTRY_W = FRACTION_BITS + 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W   = $clog2(ENTRIES);

  // fixed field widths
  localparam int OP_W     = 1;
  localparam int ROWIN_W  = 7;
  localparam int ANGLE_W  = 8;
  localparam int CDF_W    = 17;
  localparam int ENERGY_W = 11;
  localparam int RAND_W   = 16;
  localparam int IN_W     = ROWIN_W + ANGLE_W + CDF_W + ENERGY_W + RAND_W;
  localparam int TDATA_W  = ((IN_W + 7) / 8) * 8;

  // energy band: row = (energy + BAND_KEV/2) / BAND_KEV - 1 via reciprocal
  localparam int BAND_KEV    = 10;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2 ** RECIP_SHIFT + BAND_KEV - 1) / BAND_KEV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int SUM_W       = ENERGY_W + 1;
  localparam int QUO_W       = SUM_W;

  // item kinds
  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ROWIN_W-1:0]  row_index;
    logic [ANGLE_W-1:0]  angle_index;
    logic [CDF_W-1:0]    cdf_value;
    logic [ENERGY_W-1:0] energy_kev;
    logic [RAND_W-1:0]   random_value;
  } item_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

// File: src/inverse_cdf_angle_sampler.sv
// ----------------------------------------------------------------------------
// inverse_cdf_angle_sampler
// Scattering-angle sampler by inverse transform over a stored CDF table.
//
// Input channel s_*: tuser selects the kind of item (0 = store one table
// entry, 1 = sample an angle). A store item writes entry (row, angle) of the
// 70 x 181 table; indexes outside the table are dropped. A sample item picks
// the energy band row round(energy/10)-1 (at least row 0, saturated to the last row) and
// binary-searches it for the smallest angle whose entry reaches the random
// value. Output channel m_*: one angle per item, zero for store items.
//
// Timing: one item in flight at a time. A store item passes through the write
// and result states before the next accept; a sample item passes through row
// base, first read, then one RAM probe per cycle, 7 or 8 probes for 181
// entries, then the result state. The result sits in an output register, so
// the next item is accepted while it waits; a stalled receiver holds the
// sequencer only once a second result is ready.
//
// Reset clears the control state only. The table is undefined until written;
// there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_cdf_angle_sampler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [6:0] row_index, [14:7] angle_index, [31:15] cdf_value,
  // [42:32] energy_kev, [58:43] random_value, [63:59] zero
  input  wire logic [icdf_pkg::TDATA_W-1:0]  s_tdata,
  // [0] op
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [7:0] angle_deg
  output logic [icdf_pkg::ANGLE_W-1:0]       m_tdata
);

  icdf_pkg::item_t                 in_item;
  logic                            res_valid;
  logic                            res_ready;
  logic [icdf_pkg::ANGLE_W-1:0]    res_angle;
  icdf_pkg::ram_wr_t               ram_wr;
  logic [icdf_pkg::ADDR_W-1:0]     ram_raddr;
  logic [icdf_pkg::ENTRY_W-1:0]    ram_rdata;

  always_comb begin
    in_item.op           = s_tuser;
    in_item.row_index    = s_tdata[6:0];
    in_item.angle_index  = s_tdata[14:7];
    in_item.cdf_value    = s_tdata[31:15];
    in_item.energy_kev   = s_tdata[42:32];
    in_item.random_value = s_tdata[58:43];
  end

  icdf_search u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_angle (res_angle),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  icdf_ram #(
    .WIDTH (icdf_pkg::ENTRY_W),
    .DEPTH (icdf_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res_angle;
    end
  end

endmodule

`default_nettype wire

// File: src/icdf_ram.sv
// ----------------------------------------------------------------------------
// icdf_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module icdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/icdf_search.sv
// ----------------------------------------------------------------------------
// icdf_search
// Item sequencer: stores table entries and runs the binary search of one
// table row per sample item, one probe per cycle against the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module icdf_search (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire icdf_pkg::item_t                    in_item,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output logic [icdf_pkg::ANGLE_W-1:0]            res_angle,
  output icdf_pkg::ram_wr_t                       ram_wr,
  output logic [icdf_pkg::ADDR_W-1:0]             ram_raddr,
  input  wire logic [icdf_pkg::ENTRY_W-1:0]       ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [icdf_pkg::IDX_W-1:0] IDX_LAST =
    icdf_pkg::IDX_W'(icdf_pkg::ENTRIES - 1);
  localparam logic [icdf_pkg::IDX_W-1:0] IDX_MID0 = IDX_LAST >> 1;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  icdf_pkg::item_t                  item;
  logic                             wr_ok;
  logic [icdf_pkg::ROW_W-1:0]       row;
  logic [icdf_pkg::ADDR_W-1:0]      base;
  logic [icdf_pkg::IDX_W-1:0]       lo;
  logic [icdf_pkg::IDX_W-1:0]       hi;
  logic [icdf_pkg::IDX_W-1:0]       mid;
  logic [icdf_pkg::IDX_W-1:0]       lo_next;
  logic [icdf_pkg::IDX_W-1:0]       hi_next;
  logic [icdf_pkg::IDX_W-1:0]       mid_next;

  logic                             accept;
  logic [icdf_pkg::SUM_W-1:0]       band_sum;
  logic [icdf_pkg::SUM_W+icdf_pkg::RECIP_W-1:0] band_prod;
  logic [icdf_pkg::QUO_W-1:0]       band_quo;
  logic [icdf_pkg::QUO_W-1:0]       band_dec;
  logic [icdf_pkg::ROW_W-1:0]       row_sel;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // energy band by reciprocal multiply; exact over the whole 11-bit range
  always_comb begin
    band_sum  = icdf_pkg::SUM_W'(in_item.energy_kev) +
                icdf_pkg::SUM_W'(icdf_pkg::BAND_KEV / 2);
    band_prod = (icdf_pkg::SUM_W + icdf_pkg::RECIP_W)'(band_sum) *
                (icdf_pkg::SUM_W + icdf_pkg::RECIP_W)'(icdf_pkg::RECIP);
    band_quo  = icdf_pkg::QUO_W'(band_prod >> icdf_pkg::RECIP_SHIFT);
    band_dec  = (band_quo != '0) ? band_quo - 1'b1 : band_quo;
    if (band_dec > (icdf_pkg::ROWS - 1)) begin
      row_sel = icdf_pkg::ROW_W'(icdf_pkg::ROWS - 1);
    end else begin
      row_sel = icdf_pkg::ROW_W'(band_dec);
    end
  end

  // one search step on the entry read last cycle
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (ram_rdata >= icdf_pkg::ENTRY_W'(item.random_value)) begin
      hi_next = mid;
    end else begin
      lo_next = mid + 1'b1;
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

  always_comb begin
    if (state == S_START) begin
      ram_raddr = base + icdf_pkg::ADDR_W'(IDX_MID0);
    end else begin
      ram_raddr = base + icdf_pkg::ADDR_W'(mid_next);
    end
  end

  always_comb begin
    ram_wr.we   = (state == S_WR) && wr_ok;
    ram_wr.addr = icdf_pkg::ADDR_W'(item.row_index) *
                  icdf_pkg::ADDR_W'(icdf_pkg::ENTRIES) +
                  icdf_pkg::ADDR_W'(item.angle_index);
    ram_wr.data = icdf_pkg::ENTRY_W'(item.cdf_value);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_item.op == icdf_pkg::OP_WRITE) ? S_WR : S_ROW;
        end
      end
      S_WR:    state_next = S_DONE;
      S_ROW:   state_next = S_START;
      S_START: state_next = S_CMP;
      S_CMP: begin
        if (lo_next >= hi_next) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= in_item;
      row   <= row_sel;
      wr_ok <= (in_item.row_index < icdf_pkg::ROWS) &&
               (in_item.angle_index < icdf_pkg::ENTRIES);
    end
    case (state)
      S_WR: begin
        lo <= '0;
      end
      S_ROW: begin
        base <= icdf_pkg::ADDR_W'(row) * icdf_pkg::ADDR_W'(icdf_pkg::ENTRIES);
      end
      S_START: begin
        lo  <= '0;
        hi  <= IDX_LAST;
        mid <= IDX_MID0;
      end
      S_CMP: begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= mid_next;
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (state == S_DONE);
  assign res_angle = icdf_pkg::ANGLE_W'(lo);

  // search interval is never empty while a probe is in flight
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (lo < hi))
    else $error("search interval empty during probe");

  // the probe always lies inside the interval
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (mid >= lo && mid < hi))
    else $error("probe outside search interval");

  // a stored entry always lands inside the table
  assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> (ram_wr.addr < icdf_pkg::DEPTH))
    else $error("table write out of range");

  // a result never exceeds the last angle
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (lo <= IDX_LAST))
    else $error("result angle out of range");

  // a write item always returns angle zero
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |=> (res_valid && res_angle == '0))
    else $error("write item result not zero");

endmodule

`default_nettype wire

// File: test/inverse_cdf_angle_sampler_tb.sv
// ----------------------------------------------------------------------------
// inverse_cdf_angle_sampler_tb
// Drives store and sample items into the angle sampler and checks each
// returned angle against a local model of the CDF table and of its binary
// search. A sample only goes out once every entry that its search probes has
// been stored, so the store items ahead of it fill the search path with
// ramp-like values. Both sides of the stream idle at random in bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_cdf_angle_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int TARGET_ITEMS    = 1400;
  localparam int QUIET_ITEMS     = 1250;
  localparam int RAMP_STEP       = 364;   // one degree of a roughly linear CDF

  typedef struct packed {
    logic [icdf_pkg::OP_W-1:0]     op;
    logic [icdf_pkg::ROWIN_W-1:0]  row_index;
    logic [icdf_pkg::ANGLE_W-1:0]  angle_index;
    logic [icdf_pkg::CDF_W-1:0]    cdf_value;
    logic [icdf_pkg::ENERGY_W-1:0] energy_kev;
    logic [icdf_pkg::RAND_W-1:0]   random_value;
    logic                          typed;
    logic [icdf_pkg::ANGLE_W-1:0]  angle;
  } vec_t;

  localparam int DIR_N = 18;
  localparam vec_t DIR_TAB [DIR_N] = '{
    // store items, in and out of the table
    '{icdf_pkg::OP_WRITE,  7'd0,   8'd0,   17'd0,     11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd69,  8'd180, 17'd65536, 11'd2047, 16'd65535, 1'b1, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd127, 8'd0,   17'd65536, 11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd0,   8'd255, 17'd1,     11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd70,  8'd181, 17'd65535, 11'd1,    16'd1,     1'b1, 8'd0},
    // samples: lowest value, saturated search, band edges
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd127, 8'd255, 17'd65536, 11'd4,    16'd65535, 1'b1, 8'd180},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd14,   16'd364,   1'b0, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd15,   16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd2047, 16'd65535, 1'b1, 8'd180},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd694,  16'd32768, 1'b0, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd695,  16'd32768, 1'b0, 8'd0},
    // non-monotone row
    '{icdf_pkg::OP_WRITE,  7'd5,   8'd90,  17'd0,     11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd60,   16'd30000, 1'b0, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd64,  8'd128, 17'd65536, 11'd0,    16'd0,     1'b1, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd650,  16'd65535, 1'b0, 8'd0},
    '{icdf_pkg::OP_SAMPLE, 7'd0,   8'd0,   17'd0,     11'd1000, 16'd1,     1'b0, 8'd0},
    '{icdf_pkg::OP_WRITE,  7'd69,  8'd179, 17'd65536, 11'd0,    16'd0,     1'b1, 8'd0}
  };

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [icdf_pkg::TDATA_W-1:0]  s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [icdf_pkg::ANGLE_W-1:0]  m_tdata;

  // local copy of the CDF table and which entries hold a stored value
  logic [icdf_pkg::CDF_W-1:0]    cdf_rows [icdf_pkg::ROWS][icdf_pkg::ENTRIES];
  bit                            entry_set [icdf_pkg::ROWS][icdf_pkg::ENTRIES];
  logic [icdf_pkg::ANGLE_W-1:0]  angle_q [$];

  int  errors     = 0;
  int  item_count = 0;
  int  idle_count = 0;
  int  gap_pct    = 30;
  int  stall_pct  = 30;
  bit  quiet      = 1'b0;

  inverse_cdf_angle_sampler uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int band_row(logic [icdf_pkg::ENERGY_W-1:0] energy);
    int r;
    r = (int'(energy) + 5) / 10;
    if (r > 0) r--;
    if (r > icdf_pkg::ROWS - 1) r = icdf_pkg::ROWS - 1;
    return r;
  endfunction

  function automatic logic [icdf_pkg::ANGLE_W-1:0] search_angle(
    int row, logic [icdf_pkg::RAND_W-1:0] rv);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = icdf_pkg::ENTRIES - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cdf_rows[row][mid] >= {1'b0, rv}) hi = mid;
      else lo = mid + 1;
    end
    return lo[icdf_pkg::ANGLE_W-1:0];
  endfunction

  // first entry on the search path that has not been stored yet, or -1
  function automatic int first_unset_probe(int row, logic [icdf_pkg::RAND_W-1:0] rv);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = icdf_pkg::ENTRIES - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!entry_set[row][mid]) return mid;
      if (cdf_rows[row][mid] >= {1'b0, rv}) hi = mid;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic logic [icdf_pkg::ANGLE_W-1:0] apply_item(vec_t it);
    if (it.op == icdf_pkg::OP_WRITE) begin
      if (it.row_index < icdf_pkg::ROWS && it.angle_index < icdf_pkg::ENTRIES) begin
        cdf_rows[it.row_index][it.angle_index] = it.cdf_value;
        entry_set[it.row_index][it.angle_index] = 1'b1;
      end
      return '0;
    end
    return search_angle(band_row(it.energy_kev), it.random_value);
  endfunction

  function automatic logic [icdf_pkg::CDF_W-1:0] fill_value(int a, bit noisy);
    int v;
    if (!noisy) return icdf_pkg::CDF_W'(a * RAMP_STEP);
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 65536);
      1:       v = 65536;
      default: v = a * RAMP_STEP + $urandom_range(0, 600) - 300;
    endcase
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return icdf_pkg::CDF_W'(v);
  endfunction

  task automatic send_item(vec_t it);
    logic [icdf_pkg::ANGLE_W-1:0] want;
    if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {5'b0, it.random_value, it.energy_kev, it.cdf_value,
                 it.angle_index, it.row_index};
    do @(posedge clk); while (!s_tready);
    want = apply_item(it);
    angle_q.insert(angle_q.size(), it.typed ? it.angle : want);
    if (it.op == icdf_pkg::OP_SAMPLE ||
        (it.row_index < icdf_pkg::ROWS && it.angle_index < icdf_pkg::ENTRIES))
      item_count++;
  endtask

  // store whatever the search path still lacks, then sample
  task automatic sample_with_fill(vec_t it, bit noisy);
    vec_t wr;
    int   row;
    int   probe;
    row = band_row(it.energy_kev);
    probe = first_unset_probe(row, it.random_value);
    while (probe >= 0) begin
      wr = '0;
      wr.op           = icdf_pkg::OP_WRITE;
      wr.row_index    = icdf_pkg::ROWIN_W'(row);
      wr.angle_index  = icdf_pkg::ANGLE_W'(probe);
      wr.cdf_value    = fill_value(probe, noisy);
      wr.energy_kev   = noisy ? icdf_pkg::ENERGY_W'($urandom) : '0;
      wr.random_value = noisy ? icdf_pkg::RAND_W'($urandom) : '0;
      send_item(wr);
      probe = first_unset_probe(row, it.random_value);
    end
    send_item(it);
  endtask

  function automatic vec_t random_sample();
    vec_t it;
    it = '0;
    it.op          = icdf_pkg::OP_SAMPLE;
    it.row_index   = icdf_pkg::ROWIN_W'($urandom);
    it.angle_index = icdf_pkg::ANGLE_W'($urandom);
    it.cdf_value   = icdf_pkg::CDF_W'($urandom_range(0, 65536));
    it.energy_kev  = ($urandom_range(0, 9) < 4) ?
                     icdf_pkg::ENERGY_W'($urandom) :
                     icdf_pkg::ENERGY_W'($urandom_range(0, 700));
    case ($urandom_range(0, 9))
      0:       it.random_value = '0;
      1:       it.random_value = '1;
      default: it.random_value = icdf_pkg::RAND_W'($urandom);
    endcase
    return it;
  endfunction

  function automatic vec_t random_write(bit in_table);
    vec_t it;
    it = '0;
    it.op           = icdf_pkg::OP_WRITE;
    it.cdf_value    = ($urandom_range(0, 7) == 0) ?
                      icdf_pkg::CDF_W'(65536) :
                      icdf_pkg::CDF_W'($urandom_range(0, 65536));
    it.energy_kev   = icdf_pkg::ENERGY_W'($urandom);
    it.random_value = icdf_pkg::RAND_W'($urandom);
    if (in_table) begin
      it.row_index   = icdf_pkg::ROWIN_W'($urandom_range(0, icdf_pkg::ROWS - 1));
      it.angle_index = icdf_pkg::ANGLE_W'($urandom_range(0, icdf_pkg::ENTRIES - 1));
    end else begin
      it.row_index   = icdf_pkg::ROWIN_W'($urandom_range(0, 127));
      it.angle_index = icdf_pkg::ANGLE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0)
        it.row_index = icdf_pkg::ROWIN_W'($urandom_range(icdf_pkg::ROWS, 127));
      else
        it.angle_index = icdf_pkg::ANGLE_W'($urandom_range(icdf_pkg::ENTRIES, 255));
    end
    return it;
  endfunction

  // stimulus
  initial begin
    int   pick;
    int   next_mode;
    vec_t it;
    foreach (cdf_rows[r, a]) begin
      cdf_rows[r][a]  = '0;
      entry_set[r][a] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].op == icdf_pkg::OP_SAMPLE) sample_with_fill(DIR_TAB[i], 1'b0);
      else send_item(DIR_TAB[i]);
    end

    next_mode = 0;
    while (item_count < TARGET_ITEMS) begin
      if (item_count >= next_mode) begin
        next_mode = item_count + 100;
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 20;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      if (item_count >= QUIET_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 65) sample_with_fill(random_sample(), 1'b1);
      else if (pick < 88) begin
        it = random_write(1'b1);
        send_item(it);
      end else begin
        it = random_write(1'b0);
        send_item(it);
      end
    end
    s_tvalid <= 1'b0;

    while (angle_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("PASS inverse_cdf_angle_sampler");
    else $display("FAIL inverse_cdf_angle_sampler");
    $finish;
  end

  // receiver: stall in bursts, none in the final stretch
  initial begin
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // compare each returned angle with the oldest one pending
  always @(posedge clk) begin
    logic [icdf_pkg::ANGLE_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: angle with none pending, expected nothing, got %0d", $time, m_tdata);
        errors++;
      end else begin
        want = angle_q.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: angle mismatch, expected %0d, got %0d", $time, want, m_tdata);
          errors++;
        end
      end
    end
  end

  // hang detection: too long without any item moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_CYCLES) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_count);
      $display("FAIL inverse_cdf_angle_sampler");
      $finish;
    end
  end

endmodule

`default_nettype wire
